// ===== rtl/wsenc_pkg.sv =====
// Package with the request types, constants and bit-expansion helpers of the WS2812 encoder.
`timescale 1ns / 1ps

package wsenc_pkg;

  localparam int unsigned GapBytesDefault = 80;
  localparam int unsigned BrightWidth = 9;
  localparam int unsigned CodeWidth = 72;
  localparam int unsigned BytesPerPixel = 9;
  localparam int unsigned CntWidth = 4;

  localparam logic [2:0] BIT_ONE_CODE = 3'b110;
  localparam logic [2:0] BIT_ZERO_CODE = 3'b100;
  localparam logic [BrightWidth-1:0] BRIGHT_RESET = 9'd255;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_EOF   = 1'b1
  } action_t;

  typedef struct packed {
    logic        action;
    logic [23:0] color;
  } in_item_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic [7:0] repeat_res;
    logic       last;
  } out_item_t;

  // Request handed from the encoder stage into the serializer.
  typedef struct packed {
    logic                 eof;
    logic [CodeWidth-1:0] code;
  } ser_load_t;

  // Each channel bit becomes a three-bit symbol, MSB first.
  function automatic logic [23:0] expand_bits(input logic [7:0] ch);
    logic [23:0] code;
    code = '0;
    for (int i = 0; i < 8; i++) begin
      code[3*i +: 3] = ch[i] ? BIT_ONE_CODE : BIT_ZERO_CODE;
    end
    return code;
  endfunction

endpackage

// ===== rtl/ws2812_spi_pixel_encoder.sv =====
// Top level of the WS2812 SPI pixel encoder: input register, encoder and serializer.
`timescale 1ns / 1ps

// An accepted request passes the input register and the serializer's shift register
// before its bytes reach the output register. A pixel request yields nine bytes and an
// end-of-frame request yields one; each holds the serializer until its last byte leaves.
// The input register and output register let the next request enter while bytes drain.
// Reset (rst_n, synchronous, active low) empties all stages and sets brightness to 255.
module ws2812_spi_pixel_encoder #(
  parameter int unsigned GAP_BYTES = wsenc_pkg::GapBytesDefault
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  wsenc_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output wsenc_pkg::out_item_t                out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wsenc_pkg::BrightWidth-1:0]   cfg_data
);

  // Brightness register; every write is taken, unchecked. Software must only write it
  // while the pipeline is empty, so no request sees a half-applied change.
  logic [wsenc_pkg::BrightWidth-1:0] brightness_r;

  // Input register: holds one accepted request until the serializer takes it.
  logic                 in_full_r;
  wsenc_pkg::in_item_t  in_item_r;

  logic                                 ser_ready;
  logic                                 in_move;
  logic [wsenc_pkg::CodeWidth-1:0]      pixel_code;
  wsenc_pkg::ser_load_t                 ser_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= wsenc_pkg::BRIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      brightness_r <= cfg_data;
    end
  end

  // The input register frees up in the same cycle its request moves on, so
  // requests flow without a bubble whenever the serializer can take them.
  assign in_move  = in_full_r && ser_ready;
  assign in_stall = in_full_r && !ser_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full_r <= 1'b1;
    end else if (in_move) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  // Scaling and symbol expansion sit between the input register and the
  // serializer's shift register.
  wsenc_scale_encode u_scale_encode (
    .color      (in_item_r.color),
    .brightness (brightness_r),
    .code       (pixel_code)
  );

  assign ser_load.eof  = (in_item_r.action == wsenc_pkg::ACT_EOF);
  assign ser_load.code = pixel_code;

  // The serializer shifts out one byte per cycle into its output register while
  // the output is not stalled; an end-of-frame request becomes a single zero byte
  // with the reset-gap repeat count.
  wsenc_serializer #(
    .GAP_BYTES (GAP_BYTES)
  ) u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_full_r),
    .load       (ser_load),
    .load_ready (ser_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== rtl/wsenc_scale_encode.sv =====
// Brightness scaling with saturation and 3-bit symbol expansion of one pixel.
`timescale 1ns / 1ps

module wsenc_scale_encode (
  input  logic [23:0]                       color,
  input  logic [wsenc_pkg::BrightWidth-1:0] brightness,
  output logic [wsenc_pkg::CodeWidth-1:0]   code
);

  logic [7:0] ch_in  [3];
  logic [7:0] ch_out [3];
  logic [16:0] prod  [3];

  // Wire order is green, red, blue.
  assign ch_in[0] = color[15:8];
  assign ch_in[1] = color[23:16];
  assign ch_in[2] = color[7:0];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = {9'd0, ch_in[c]} * {8'd0, brightness};
      // A product of 256 or more after the shift clamps to full scale.
      ch_out[c] = prod[c][16] ? 8'hFF : prod[c][15:8];
    end
  end

  assign code = {wsenc_pkg::expand_bits(ch_out[0]),
                 wsenc_pkg::expand_bits(ch_out[1]),
                 wsenc_pkg::expand_bits(ch_out[2])};

endmodule

// ===== rtl/wsenc_serializer.sv =====
// Byte serializer with its own output register for the encoded pixel stream.
`timescale 1ns / 1ps

module wsenc_serializer #(
  parameter int unsigned GAP_BYTES = wsenc_pkg::GapBytesDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load_valid,
  input  wsenc_pkg::ser_load_t load,
  output logic                 load_ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wsenc_pkg::out_item_t out_data
);

  logic                                busy_r;
  logic                                eof_r;
  logic [wsenc_pkg::CodeWidth-1:0]     code_r;
  logic [wsenc_pkg::CntWidth-1:0]      cnt_r;
  logic                                out_valid_r;
  wsenc_pkg::out_item_t                out_data_r;

  logic                                out_free;
  logic                                emit;
  logic                                emit_last;
  wsenc_pkg::out_item_t                emit_item;

  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = busy_r && out_free;
  assign emit_last = eof_r ||
                     (cnt_r == wsenc_pkg::CntWidth'(wsenc_pkg::BytesPerPixel - 1));
  // A new pixel may load while the final byte of the current one leaves.
  assign load_ready = !busy_r || (emit && emit_last);

  always_comb begin
    if (eof_r) begin
      emit_item.spi_byte   = 8'd0;
      emit_item.repeat_res = 8'(GAP_BYTES);
    end else begin
      emit_item.spi_byte   = code_r[wsenc_pkg::CodeWidth-1 -: 8];
      emit_item.repeat_res = 8'd1;
    end
    emit_item.last = emit_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      eof_r       <= 1'b0;
    end else begin
      if (load_valid && load_ready) begin
        busy_r <= 1'b1;
        eof_r  <= load.eof;
        cnt_r  <= '0;
      end else if (emit) begin
        cnt_r <= cnt_r + 1'b1;
        if (emit_last) begin
          busy_r <= 1'b0;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      code_r <= load.code;
    end else if (emit) begin
      code_r <= {code_r[wsenc_pkg::CodeWidth-9:0], 8'd0};
    end
    if (emit) begin
      out_data_r <= emit_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== dv/tb_ws2812_spi_pixel_encoder.sv =====
// Self-checking testbench of the WS2812 SPI pixel encoder: directed table, then random requests.
`timescale 1ns / 1ps

// The bench drives pixel and end-of-frame requests into the encoder and checks every SPI byte
// that comes back. A predictor scales each channel by the current brightness, expands each
// bit into a three-bit symbol and queues the nine bytes of a pixel in green, red, blue order.
// For an end of frame it queues the single reset-gap byte. The monitor pops one expected
// byte for each byte that the output side accepts and compares the fields one by one.
module tb_ws2812_spi_pixel_encoder;

  localparam int unsigned RESET_LEN = 80;
  // A correct run never goes this long without some handshake completing, even at the
  // heaviest output stall rate.
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned RANDOM_PER_PHASE = 137;
  localparam int unsigned ITEMS_PER_SETTING = 48;
  // A request passes the input, shift and output registers on its way out; this leaves margin.
  localparam int unsigned DRAIN_CYCLES = 6;

  // One row of the directed table. A row either writes brightness or sends a request.
  // Rows with typed set carry the expected 72-bit pixel code written out by hand.
  typedef struct {
    bit                                is_cfg;
    logic [wsenc_pkg::BrightWidth-1:0] bright;
    wsenc_pkg::in_item_t               req;
    bit                                typed;
    logic [wsenc_pkg::CodeWidth-1:0]   code;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  wsenc_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  wsenc_pkg::out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [wsenc_pkg::BrightWidth-1:0] cfg_data = '0;

  // Brightness as the block should hold it, and the SPI bytes still owed by the block.
  logic [wsenc_pkg::BrightWidth-1:0] bright_now = wsenc_pkg::BRIGHT_RESET;
  wsenc_pkg::out_item_t spi_expect_q[$];

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int n_err = 0;
  int n_pix = 0;
  int n_frames = 0;
  int n_cfg = 0;
  int n_bytes = 0;
  int idle_cycles = 0;

  ws2812_spi_pixel_encoder #(
    .GAP_BYTES(RESET_LEN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor.
  // ---------------------------------------------------------------------------------------

  // Channel times brightness, shifted right by eight. Brightness above 256 can push the
  // product past 255, in which case the channel saturates instead of wrapping.
  function automatic logic [7:0] scale_chan(input logic [7:0] ch,
                                            input logic [wsenc_pkg::BrightWidth-1:0] br);
    logic [16:0] prod;
    prod = ch * br;
    return (prod[16:8] > 9'd255) ? 8'hff : prod[15:8];
  endfunction

  // Each channel bit, MSB first, becomes 110 for a one and 100 for a zero.
  function automatic logic [23:0] spi_symbols(input logic [7:0] v);
    logic [23:0] s;
    s = '0;
    for (int i = 7; i >= 0; i--) begin
      s = {s[20:0], v[i] ? wsenc_pkg::BIT_ONE_CODE : wsenc_pkg::BIT_ZERO_CODE};
    end
    return s;
  endfunction

  // Split a pixel code into its nine bytes, most significant first; the ninth closes it.
  task automatic queue_pixel_bytes(input logic [wsenc_pkg::CodeWidth-1:0] code);
    wsenc_pkg::out_item_t o;
    for (int k = 0; k < wsenc_pkg::BytesPerPixel; k++) begin
      o.spi_byte   = code[wsenc_pkg::CodeWidth-1-8*k -: 8];
      o.repeat_res = 8'd1;
      o.last       = (k == wsenc_pkg::BytesPerPixel - 1);
      spi_expect_q.push_back(o);
    end
  endtask

  // The end of a frame is one zero byte repeated for the whole reset gap. The color
  // field plays no part in it.
  task automatic queue_reset_gap();
    wsenc_pkg::out_item_t o;
    o.spi_byte   = 8'h00;
    o.repeat_res = 8'(RESET_LEN);
    o.last       = 1'b1;
    spi_expect_q.push_back(o);
  endtask

  task automatic predict_request(input wsenc_pkg::in_item_t req);
    if (req.action == wsenc_pkg::ACT_EOF) begin
      queue_reset_gap();
    end else begin
      queue_pixel_bytes({spi_symbols(scale_chan(req.color[15:8], bright_now)),
                         spi_symbols(scale_chan(req.color[23:16], bright_now)),
                         spi_symbols(scale_chan(req.color[7:0], bright_now))});
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Drivers.
  // ---------------------------------------------------------------------------------------

  // Offer one request after a random number of idle cycles and hold it until the block
  // takes it. Valid stays high on return, so back-to-back requests need no extra edge.
  // The expected bytes are queued at the edge where the request is accepted.
  task automatic send_req(input wsenc_pkg::in_item_t req, input bit typed,
                          input logic [wsenc_pkg::CodeWidth-1:0] code);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    if (req.action == wsenc_pkg::ACT_EOF) begin
      n_frames++;
      queue_reset_gap();
    end else begin
      n_pix++;
      if (typed) queue_pixel_bytes(code);
      else predict_request(req);
    end
  endtask

  // Brightness changes only while the block is idle: all owed bytes have come back and
  // the drain margin has passed.
  task automatic write_brightness(input logic [wsenc_pkg::BrightWidth-1:0] v);
    in_valid <= 1'b0;
    while (spi_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bright_now = v;
    n_cfg++;
  endtask

  // The output side stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // ---------------------------------------------------------------------------------------
  // Monitor and watchdog.
  // ---------------------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
      n_err++;
    end
  endtask

  always @(posedge clk) begin : byte_monitor
    wsenc_pkg::out_item_t exp_o;
    if (rst_n && out_valid && !out_stall) begin
      n_bytes++;
      if (spi_expect_q.size() == 0) begin
        $display("%0t: unexpected SPI byte, expected none, got %h", $time, out_data);
        n_err++;
      end else begin
        exp_o = spi_expect_q.pop_front();
        check_field("spi_byte", exp_o.spi_byte, out_data.spi_byte);
        check_field("repeat_res", exp_o.repeat_res, out_data.repeat_res);
        check_field("last", 8'(exp_o.last), 8'(out_data.last));
      end
    end
  end

  // Counts cycles in which no handshake of any kind completes.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------------------

  function automatic stim_row_t pix_row(input logic [23:0] color);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.bright = '0;
    r.req.action = wsenc_pkg::ACT_PIXEL;
    r.req.color = color;
    r.typed = 1'b0;
    r.code = '0;
    return r;
  endfunction

  function automatic stim_row_t pix_row_typed(input logic [23:0] color,
                                              input logic [wsenc_pkg::CodeWidth-1:0] code);
    stim_row_t r;
    r = pix_row(color);
    r.typed = 1'b1;
    r.code = code;
    return r;
  endfunction

  function automatic stim_row_t frame_end_row(input logic [23:0] color);
    stim_row_t r;
    r = pix_row(color);
    r.req.action = wsenc_pkg::ACT_EOF;
    return r;
  endfunction

  function automatic stim_row_t bright_row(input logic [wsenc_pkg::BrightWidth-1:0] v);
    stim_row_t r;
    r = pix_row('0);
    r.is_cfg = 1'b1;
    r.bright = v;
    return r;
  endfunction

  // Random requests: mostly pixels, about one in ten ends a frame. Each channel is
  // forced to all zeros or all ones now and then so the extremes keep coming up.
  function automatic wsenc_pkg::in_item_t rand_req();
    wsenc_pkg::in_item_t r;
    int sel;
    r.color = 24'($urandom);
    for (int c = 0; c < 3; c++) begin
      sel = $urandom_range(7);
      if (sel == 0) r.color[8*c +: 8] = 8'h00;
      else if (sel == 1) r.color[8*c +: 8] = 8'hff;
    end
    r.action = ($urandom_range(9) == 0) ? wsenc_pkg::ACT_EOF : wsenc_pkg::ACT_PIXEL;
    return r;
  endfunction

  function automatic logic [wsenc_pkg::BrightWidth-1:0] pick_brightness();
    case ($urandom_range(5))
      0: return 9'd0;
      1: return 9'd256;
      2: return 9'd511;
      3: return 9'($urandom_range(511, 257));
      default: return 9'($urandom_range(256));
    endcase
  endfunction

  initial begin
    stim_row_t dir_tab[$];

    // Directed part. Brightness is at its reset value for the first rows. Uniform
    // colors that scale to 0 or 255 give codes that are easy to write out: all-zero
    // symbols are 924924 per channel and all-one symbols are DB6DB6.
    dir_tab.push_back(frame_end_row(24'h000000));
    dir_tab.push_back(frame_end_row(24'hffffff));
    dir_tab.push_back(pix_row_typed(24'h000000, 72'h924924_924924_924924));
    dir_tab.push_back(pix_row(24'hffffff));
    dir_tab.push_back(pix_row(24'hff0000));
    dir_tab.push_back(pix_row(24'h00ff00));
    dir_tab.push_back(pix_row(24'h0000ff));
    dir_tab.push_back(pix_row(24'haa55aa));
    dir_tab.push_back(pix_row(24'h55aa55));
    // At 256 every channel passes through unchanged.
    dir_tab.push_back(bright_row(9'd256));
    dir_tab.push_back(pix_row_typed(24'hffffff, 72'hdb6db6_db6db6_db6db6));
    dir_tab.push_back(pix_row(24'h123456));
    // At zero every pixel goes dark, but the frame end still carries the reset gap.
    dir_tab.push_back(bright_row(9'd0));
    dir_tab.push_back(pix_row_typed(24'hffffff, 72'h924924_924924_924924));
    dir_tab.push_back(frame_end_row(24'h5a5a5a));
    // At the top of the range bright channels saturate at 255 rather than wrapping.
    dir_tab.push_back(bright_row(9'd511));
    dir_tab.push_back(pix_row_typed(24'hffffff, 72'hdb6db6_db6db6_db6db6));
    dir_tab.push_back(pix_row_typed(24'h818181, 72'hdb6db6_db6db6_db6db6));
    dir_tab.push_back(pix_row(24'h010101));
    dir_tab.push_back(pix_row(24'h7f8081));
    dir_tab.push_back(bright_row(9'd1));
    dir_tab.push_back(pix_row_typed(24'hffffff, 72'h924924_924924_924924));
    dir_tab.push_back(pix_row(24'h800000));
    dir_tab.push_back(bright_row(wsenc_pkg::BRIGHT_RESET));
    dir_tab.push_back(pix_row(24'h010203));

    in_idle_pct = 36;
    out_stall_pct = 79;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_brightness(dir_tab[i].bright);
      else send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].code);
    end

    // Random part in three phases: sender idles lightly while the receiver stalls
    // heavily, then the reverse, then both run flat out. Brightness changes every
    // few dozen requests.
    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct   = (ph == 0) ? 36 : (ph == 1) ? 79 : 0;
      out_stall_pct = (ph == 0) ? 79 : (ph == 1) ? 36 : 0;
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        if (k % ITEMS_PER_SETTING == 0) write_brightness(pick_brightness());
        send_req(rand_req(), 1'b0, '0);
      end
    end

    // Let the last bytes drain, then watch a little longer for anything extra.
    in_valid <= 1'b0;
    while (spi_expect_q.size() != 0) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pixels and %0d frame ends under %0d brightness writes.",
             n_pix, n_frames, n_cfg);
    $display("Checked %0d SPI bytes across three stall and idle mixes.", n_bytes);
    if (n_err == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
